@@ rtl/pd_pkg.sv @@
// pd_pkg: shared types, constants and helpers of the percent decoder
// no dependencies; used by pd_front, pd_queue, pd_back and percent_decoder
`default_nettype none

package pd_pkg;

	localparam int QDepth = 4;
	localparam int QAW    = $clog2(QDepth);
	localparam int QCW    = $clog2(QDepth + 1);

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] REPL_HI    = 8'hFF;
	localparam logic [7:0] REPL_LO    = 8'hFD;

	localparam logic CFG_IDX_MODE = 1'b0;
	localparam logic CFG_IDX_PLUS = 1'b1;

	typedef enum logic [1:0] {
		MODE_FAIL = 2'd0,
		MODE_REPL = 2'd1,
		MODE_IGN  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_HANDLED = 2'd1,
		ST_FAIL    = 2'd2,
		ST_BAD     = 2'd3
	} st_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_DIG  = 2'd2
	} ph_t;

	// one classified input word: up to two data bytes, then an optional status
	typedef struct packed {
		logic [1:0] n_data;
		logic [7:0] d0;
		logic [7:0] d1;
		logic       has_status;
		st_t        status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

	// bit 4 set when c is a hex digit, low nibble its value
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pd_if.sv @@
// pd_in_if and pd_out_if: valid/ready channels of the percent decoder
// no dependencies
`default_nettype none

interface pd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface pd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_status;
	logic [1:0] status;
	logic       last_of_run;

	modport source (output valid, output out_byte, output is_status, output status,
		output last_of_run, input ready);
	modport sink (input valid, input out_byte, input is_status, input status,
		input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/pd_front.sv @@
// pd_front: accepts encoded bytes, tracks escapes and string status,
// and classifies each word into a result command; depends on pd_pkg, pd_if
`default_nettype none

module pd_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [1:0]  cfg_data,
	pd_in_if.sink            in_ch,
	input  pd_pkg::q_flags_t q_flags,
	output logic             push,
	output pd_pkg::cmd_t     cmd
);
	import pd_pkg::*;

	logic [1:0] error_mode_q;
	logic       plus_is_space_q;
	ph_t        phase_q;
	logic [7:0] held_q;
	st_t        run_status_q;

	mode_t      mode;
	st_t        rs;
	ph_t        nph;
	logic [7:0] nheld;
	logic       err;
	logic       plain;
	logic [7:0] pb;
	logic [4:0] hv_hi;
	logic [4:0] hv_lo;
	logic       acc;

	assign in_ch.ready = !q_flags.full;
	assign acc         = in_ch.valid && in_ch.ready;
	assign push        = acc && (cmd.n_data != 2'd0 || cmd.has_status);

	always_comb begin
		mode  = (error_mode_q > 2'(MODE_IGN)) ? MODE_IGN : mode_t'(error_mode_q);
		rs    = run_status_q;
		nph   = phase_q;
		nheld = held_q;
		err   = 1'b0;
		plain = 1'b0;
		hv_hi = hex_value(held_q);
		hv_lo = hex_value(in_ch.in_byte);
		cmd   = '0;

		if (mode == MODE_FAIL && in_ch.in_byte[7])
			rs = ST_BAD;

		if (rs == ST_FAIL || rs == ST_BAD) begin
			nph = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (in_ch.in_byte == CHAR_PCT) begin
						if (in_ch.last)
							err = 1'b1;
						else
							nph = PH_PCT;
					end else begin
						plain = 1'b1;
					end
				end
				PH_PCT: begin
					if (in_ch.last) begin
						nph = PH_IDLE;
						err = 1'b1;
						// ignore mode reprocesses a lone trailing byte as plain
						plain = (mode == MODE_IGN) && (in_ch.in_byte != CHAR_PCT);
					end else begin
						nheld = in_ch.in_byte;
						nph   = PH_DIG;
					end
				end
				PH_DIG: begin
					nph = PH_IDLE;
					if (hv_hi[4] && hv_lo[4]) begin
						cmd.n_data = 2'd1;
						cmd.d0     = {hv_hi[3:0], hv_lo[3:0]};
					end else begin
						err = 1'b1;
					end
				end
				default: nph = PH_IDLE;
			endcase
		end

		if (err) begin
			unique case (mode)
				MODE_FAIL: rs = ST_FAIL;
				MODE_REPL: begin
					rs         = ST_HANDLED;
					cmd.n_data = 2'd2;
					cmd.d0     = REPL_HI;
					cmd.d1     = REPL_LO;
				end
				MODE_IGN: rs = ST_HANDLED;
				default:  rs = ST_HANDLED;
			endcase
		end

		pb = (in_ch.in_byte == CHAR_PLUS && plus_is_space_q) ? CHAR_SPACE : in_ch.in_byte;
		if (plain) begin
			if (cmd.n_data == 2'd0)
				cmd.d0 = pb;
			else
				cmd.d1 = pb;
			cmd.n_data = cmd.n_data + 2'd1;
		end

		cmd.status = rs;
		if (in_ch.last) begin
			cmd.has_status = 1'b1;
			nph            = PH_IDLE;
			nheld          = 8'd0;
			rs             = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_mode_q    <= 2'(MODE_FAIL);
			plus_is_space_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_IDX_MODE)
				error_mode_q <= cfg_data;
			else if (cfg_idx == CFG_IDX_PLUS)
				plus_is_space_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			held_q       <= 8'd0;
			run_status_q <= ST_OK;
		end else if (acc) begin
			phase_q      <= nph;
			held_q       <= nheld;
			run_status_q <= rs;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pd_queue.sv @@
// pd_queue: small command queue between front and back of the decoder
// depends on pd_pkg
`default_nettype none

module pd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  pd_pkg::cmd_t       wr_cmd,
	input  wire logic          pop,
	output pd_pkg::cmd_t       head,
	output pd_pkg::q_flags_t   flags
);
	import pd_pkg::*;

	cmd_t           mem_q [QDepth];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign flags.full  = (count_q == QCW'(QDepth));
	assign flags.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop)
				count_q <= count_q + QCW'(1);
			else if (pop && !push)
				count_q <= count_q - QCW'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/pd_back.sv @@
// pd_back: walks each queued command and drives one result word per cycle
// into the output register while out_ch takes them; depends on pd_pkg, pd_if
`default_nettype none

module pd_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  pd_pkg::cmd_t     head,
	input  pd_pkg::q_flags_t q_flags,
	output logic             pop,
	pd_out_if.source         out_ch
);
	import pd_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] total;
	logic       last_res;
	logic       load;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       is_status_q;
	logic [1:0] status_q;
	logic       lor_q;

	assign total    = head.n_data + 2'(head.has_status);
	assign last_res = (idx_q == total - 2'd1);
	assign load     = !q_flags.empty && (!valid_q || out_ch.ready);
	assign pop      = load && last_res;

	assign out_ch.valid       = valid_q;
	assign out_ch.out_byte    = byte_q;
	assign out_ch.is_status   = is_status_q;
	assign out_ch.status      = status_q;
	assign out_ch.last_of_run = lor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (out_ch.ready)
				valid_q <= 1'b0;
			if (load)
				idx_q <= last_res ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lor_q <= last_res;
			if (idx_q < head.n_data) begin
				byte_q      <= (idx_q == 2'd0) ? head.d0 : head.d1;
				is_status_q <= 1'b0;
				status_q    <= 2'(ST_OK);
			end else begin
				byte_q      <= 8'd0;
				is_status_q <= 1'b1;
				status_q    <= 2'(head.status);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/percent_decoder.sv @@
// Percent decoder: takes one encoded byte per cycle on in_ch while the queue
// has room and gives decoded bytes, then an end-of-string status word, on
// out_ch. The front accepts a byte whenever the four-entry command queue has
// room; each byte yields zero to three result words, and the back drives one
// result word per cycle through its output register while out_ch takes them.
// Sustained rate is one byte per cycle as long as bytes average at most one
// result; escapes and replacement pairs are absorbed by the queue, and bursts
// beyond that stall the input. Results go via the queue and output register.
// depends on pd_pkg, pd_if, pd_front, pd_queue, pd_back
`default_nettype none

module percent_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_idx,
	input  wire logic [1:0] cfg_data,
	pd_in_if.sink           in_ch,
	pd_out_if.source        out_ch
);
	import pd_pkg::*;

	cmd_t     wr_cmd;
	cmd_t     head;
	q_flags_t q_flags;
	logic     push;
	logic     pop;

	pd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.q_flags  (q_flags),
		.push     (push),
		.cmd      (wr_cmd)
	);

	pd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.flags  (q_flags)
	);

	pd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_flags (q_flags),
		.pop     (pop),
		.out_ch  (out_ch)
	);

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_flags.full |-> !push)
		else $error("command pushed into full queue");

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.is_status |-> out_ch.last_of_run && out_ch.out_byte == 8'd0)
		else $error("status word not closing its run");

	a_data_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.is_status |-> out_ch.status == 2'(ST_OK))
		else $error("data word carries a status code");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.last |-> push && wr_cmd.has_status)
		else $error("last byte did not queue a status");
`endif

endmodule

`default_nettype wire
